// File: sv/wavegen_pkg.sv
// Shared types, codes and constants of the periodic waveform generator.
// Holds the controller/datapath command and status structs and the
// elaboration-time sine table arithmetic. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wavegen_pkg;

   // Waveform mode codes; codes above triangle behave as triangle
   localparam logic [2:0] MODE_SINE    = 3'd0;
   localparam logic [2:0] MODE_COSINE  = 3'd1;
   localparam logic [2:0] MODE_SQUARE  = 3'd2;
   localparam logic [2:0] MODE_RISE    = 3'd3;
   localparam logic [2:0] MODE_FALL    = 3'd4;
   localparam logic [2:0] MODE_TRIANGLE = 3'd5;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAVE_MODE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD        = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // Register reset values
   localparam int PERIOD_RESET = 100;
   localparam logic [2:0] MODE_RESET = MODE_SINE;
   localparam logic [1:0] CHANNEL_RESET = 2'd1;

   // Sample constants
   localparam int SAMPLE_W = 16;
   localparam int MAG_W    = 15;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] RAMP_SPAN  = 16'hFFFF;
   localparam logic [MAG_W-1:0]    MAG_FULL   = 15'h7FFF;

   // pi in Q60
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

   // Controller state, one-hot
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_LOOKUP = 4'b0100,
      ST_FORM   = 4'b1000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic div_start;  // launch both dividers
      logic capture;    // register table magnitude and ramp product
      logic load;       // load output stage and advance the phase
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_busy;
      logic out_busy;
   } dp_status_type;

   // 64-bit unsigned divide, elaboration only (table build)
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Q62 product
   function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] pr;
      pr = {64'd0, a} * {64'd0, b};
      return pr[125:62];
   endfunction

   // sin(x) for x in [0, pi/2], Q62 in and out, Taylor series
   function automatic logic [63:0] q62_sin(input logic [63:0] x);
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] x2;
      sum  = x;
      term = x;
      x2   = q62_mul(x, x);
      for (int n = 1; n < 24; n++) begin
         if (term != '0) begin
            term = udiv64(q62_mul(term, x2), 64'((2 * n) * (2 * n + 1)));
            if ((n % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      return sum;
   endfunction

   // trunc(32767*sin(2*pi*m/2^table_bits)) for m in [0, quarter]
   function automatic logic [MAG_W-1:0] quarter_mag(input int unsigned m, input int table_bits);
      logic [127:0] pr;
      logic [63:0]  x;
      logic [63:0]  v;
      int           sh;
      sh = table_bits - 3;
      if (m == 0) begin
         return '0;
      end
      if (m >= (32'd1 << (table_bits - 2))) begin
         return MAG_FULL;
      end
      pr = {64'd0, PI_Q60} * {96'd0, m};
      x  = 64'(pr >> sh);
      pr = {64'd0, q62_sin(x)} * 128'd32767;
      v  = 64'(pr >> 62);
      return (v > 64'd32767) ? MAG_FULL : v[MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: sv/wavegen_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Keeps only the low QUO_W quotient bits. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module wavegen_div #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 16,
   parameter int QUO_W = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start_i,
   input  wire logic [NUM_W-1:0] numer_i,
   input  wire logic [DEN_W-1:0] denom_i,
   output logic                  busy_o,
   output logic [QUO_W-1:0]      quot_o
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   // One trial subtract per cycle
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff  = trial - {1'b0, denom_i};
      fits  = (trial >= {1'b0, denom_i});
   end

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start_i) begin
         num_in  = numer_i;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy_o = busy_ff;
   assign quot_o = quo_ff;

`ifndef ASSERT_OFF
   a_start_loads_count: assert property (@(posedge clock) disable iff (reset)
      start_i |=> busy_ff && (cnt_ff == CNT_W'(NUM_W)))
      else $error("divider did not start a full pass");
`endif

endmodule

`default_nettype wire

// File: sv/wavegen_ctrl.sv
// Sequencing state machine of the waveform generator: accepts a request,
// runs the dividers, table lookup and output load. Uses wavegen_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wavegen_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_frame_request,
   output logic                            req_ready,
   input  wire wavegen_pkg::dp_status_type status_i,
   output wavegen_pkg::ctrl_cmd_type       cmd_o
);

   import wavegen_pkg::*;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_frame_request) begin
               cmd_o.div_start = 1'b1;
               state_in        = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (!status_i.div_busy) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd_o.capture = 1'b1;
            state_in      = ST_FORM;
         end
         ST_FORM: begin
            // hold until the output stage can take the new sample
            if (!status_i.out_busy) begin
               cmd_o.load = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Requests with frame_request low are taken and dropped in idle
   assign req_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// File: sv/wavegen_dp.sv
// Datapath of the waveform generator: phase state, dividers, sine table,
// ramp multiply, sample select and output stage. Uses wavegen_pkg, wavegen_div.
`timescale 1ns / 1ps
`default_nettype none

module wavegen_dp #(
   parameter int TABLE_BITS  = 12,
   parameter int PERIOD_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire wavegen_pkg::ctrl_cmd_type cmd_i,
   output wavegen_pkg::dp_status_type     status_o,
   input  wire logic [2:0]                wave_mode_i,
   input  wire logic [PERIOD_BITS-1:0]    period_i,
   input  wire logic [1:0]                channel_count_i,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output logic signed [15:0]             rsp_sample,
   output logic                           rsp_channel_index,
   output logic                           rsp_last_of_frame
);

   import wavegen_pkg::*;

   localparam int QTAB_DEPTH = 2 ** (TABLE_BITS - 2) + 1;
   localparam logic [TABLE_BITS-1:0] TBL_QUARTER = TABLE_BITS'(2 ** (TABLE_BITS - 2));
   localparam logic [TABLE_BITS-2:0] QTR_ADDR    = (TABLE_BITS-1)'(2 ** (TABLE_BITS - 2));

   typedef logic [MAG_W-1:0] qtab_type [QTAB_DEPTH];

   // Quarter-wave sine magnitudes, built at elaboration
   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int m = 0; m < QTAB_DEPTH; m++) begin
         t[m] = quarter_mag(m, TABLE_BITS);
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   logic [PERIOD_BITS-1:0] pos_ff, pos_in;
   logic                   ramp_ff, ramp_in;
   logic [PERIOD_BITS-1:0] period_eff;
   logic [TABLE_BITS-1:0]  idx_q;
   logic [SAMPLE_W-1:0]    step_q;
   logic                   idx_busy;
   logic                   step_busy;
   logic [TABLE_BITS-1:0]  tbl_idx;
   logic [TABLE_BITS-2:0]  qtr_addr;
   logic [PERIOD_BITS+SAMPLE_W-1:0] prod_full;
   logic [MAG_W-1:0]       mag_ff;
   logic                   neg_ff;
   logic [SAMPLE_W-1:0]    prod_ff;
   logic [SAMPLE_W-1:0]    sample_new;
   logic [SAMPLE_W-1:0]    rise_val;
   logic [SAMPLE_W-1:0]    fall_val;
   logic [PERIOD_BITS:0]   pos_next;
   logic                   wrap;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_chan_ff, out_chan_in;
   logic                   out_stereo_ff;
   logic [SAMPLE_W-1:0]    sample_ff;
   logic                   out_pop;

   // A zero period behaves as one
   assign period_eff = (period_i == '0) ? PERIOD_BITS'(1) : period_i;

   // Table index: low bits of floor(pos * 2^TABLE_BITS / period)
   wavegen_div #(
      .NUM_W (PERIOD_BITS + TABLE_BITS),
      .DEN_W (PERIOD_BITS),
      .QUO_W (TABLE_BITS)
   ) u_idx_div (
      .clock   (clock),
      .reset   (reset),
      .start_i (cmd_i.div_start),
      .numer_i ({pos_ff, {TABLE_BITS{1'b0}}}),
      .denom_i (period_eff),
      .busy_o  (idx_busy),
      .quot_o  (idx_q)
   );

   // Ramp step: floor(65535 / period)
   wavegen_div #(
      .NUM_W (SAMPLE_W),
      .DEN_W (PERIOD_BITS),
      .QUO_W (SAMPLE_W)
   ) u_step_div (
      .clock   (clock),
      .reset   (reset),
      .start_i (cmd_i.div_start),
      .numer_i (RAMP_SPAN),
      .denom_i (period_eff),
      .busy_o  (step_busy),
      .quot_o  (step_q)
   );

   // Fold the table index onto the quarter wave
   always_comb begin
      tbl_idx  = (wave_mode_i == MODE_COSINE) ? TABLE_BITS'(idx_q + TBL_QUARTER) : idx_q;
      qtr_addr = tbl_idx[TABLE_BITS-2] ? (QTR_ADDR - {1'b0, tbl_idx[TABLE_BITS-3:0]})
                                        : {1'b0, tbl_idx[TABLE_BITS-3:0]};
      prod_full = pos_ff * step_q;
   end

   // Register table magnitude, sign and ramp product
   always_ff @(posedge clock) begin
      if (cmd_i.capture) begin
         mag_ff  <= QTAB[qtr_addr];
         neg_ff  <= tbl_idx[TABLE_BITS-1];
         prod_ff <= prod_full[SAMPLE_W-1:0];
      end
   end

   // Select the sample by mode
   always_comb begin
      rise_val = SAMPLE_MIN + prod_ff;
      fall_val = SAMPLE_MAX - prod_ff;
      case (wave_mode_i)
         MODE_SINE, MODE_COSINE: begin
            sample_new = neg_ff ? (SAMPLE_W'(0) - {1'b0, mag_ff}) : {1'b0, mag_ff};
         end
         MODE_SQUARE: begin
            sample_new = (pos_ff < (period_eff >> 1)) ? SAMPLE_MIN : SAMPLE_MAX;
         end
         MODE_RISE: begin
            sample_new = rise_val;
         end
         MODE_FALL: begin
            sample_new = fall_val;
         end
         default: begin
            sample_new = ramp_ff ? rise_val : fall_val;
         end
      endcase
   end

   // Advance the phase, flip the triangle direction at a wrap
   always_comb begin
      pos_next = {1'b0, pos_ff} + (PERIOD_BITS+1)'(1);
      wrap     = (pos_next >= {1'b0, period_eff});
      pos_in   = pos_ff;
      ramp_in  = ramp_ff;
      if (cmd_i.load) begin
         pos_in = wrap ? '0 : pos_next[PERIOD_BITS-1:0];
         if (wrap && (wave_mode_i >= MODE_TRIANGLE)) begin
            ramp_in = !ramp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ramp_ff <= 1'b1;
      end else begin
         pos_ff  <= pos_in;
         ramp_ff <= ramp_in;
      end
   end

   // Output stage: one copy per channel
   assign out_pop = rsp_valid_ff && rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_chan_in  = out_chan_ff;
      if (cmd_i.load) begin
         rsp_valid_in = 1'b1;
         out_chan_in  = 1'b0;
      end else if (out_pop) begin
         if (rsp_last_of_frame) begin
            rsp_valid_in = 1'b0;
         end else begin
            out_chan_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         out_chan_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         out_chan_ff  <= out_chan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         sample_ff     <= sample_new;
         out_stereo_ff <= channel_count_i[1];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample        = sample_ff;
   assign rsp_channel_index = out_chan_ff;
   assign rsp_last_of_frame = !out_stereo_ff || out_chan_ff;

   assign status_o.div_busy = idx_busy || step_busy;
   assign status_o.out_busy = rsp_valid_ff && !(out_pop && rsp_last_of_frame);

`ifndef ASSERT_OFF
   a_load_after_divide: assert property (@(posedge clock) disable iff (reset)
      cmd_i.load |-> !(idx_busy || step_busy))
      else $error("output loaded while a divider is running");

   a_phase_moves_on_load: assert property (@(posedge clock) disable iff (reset)
      !cmd_i.load |=> $stable(pos_ff) && $stable(ramp_ff))
      else $error("phase state changed without a load");

   a_second_copy_stereo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_chan_ff |-> out_stereo_ff)
      else $error("right channel copy in mono frame");
`endif

endmodule

`default_nettype wire

// File: sv/periodic_waveform_generator_core.sv
// Top level of the periodic waveform generator: configuration registers,
// controller and datapath. Uses wavegen_pkg, wavegen_ctrl, wavegen_dp.
//
// Usage:
//   req_ channel: one request per frame. A request with req_frame_request
//   high produces one signed 16-bit sample; one with it low is taken and
//   produces nothing. rsp_ channel: the sample once per channel (one copy
//   mono, two stereo); rsp_last_of_frame marks the final copy.
//   csr_ port: write wave_mode, period_samples and channel_count while idle.
// Timing:
//   After acceptance a request runs through the dividers, the table lookup
//   and the output load before rsp_valid rises; the table-index divider,
//   one quotient bit per cycle over PERIOD_BITS + TABLE_BITS bits, is the
//   longer of the two, and the ramp-step divider runs beside it. The next
//   request is accepted in the cycle after the output stage is loaded.
// Reset:
//   Synchronous; phase to zero, triangle rising, sine mode, period 100, mono.
// Stall:
//   While rsp_ready is low the copy holds. A finished sample waits in the
//   datapath until the output stage drains, and no request is taken then.
`timescale 1ns / 1ps
`default_nettype none

module periodic_waveform_generator_core #(
   parameter int TABLE_BITS  = 12,
   parameter int PERIOD_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic                                    req_frame_request,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic signed [15:0]                           rsp_sample,
   output logic                                         rsp_channel_index,
   output logic                                         rsp_last_of_frame,
   input  wire logic                                    csr_write_enable,
   input  wire logic [wavegen_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [PERIOD_BITS-1:0]                  csr_write_data
);

   import wavegen_pkg::*;

   logic [2:0]             wave_mode_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [1:0]             channel_count_ff;
   ctrl_cmd_type           cmd;
   dp_status_type          status;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_mode_ff     <= MODE_RESET;
         period_ff        <= PERIOD_BITS'(PERIOD_RESET);
         channel_count_ff <= CHANNEL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_WAVE_MODE: begin
               wave_mode_ff <= csr_write_data[2:0];
            end
            CSR_PERIOD: begin
               period_ff <= csr_write_data;
            end
            CSR_CHANNEL_COUNT: begin
               channel_count_ff <= csr_write_data[1:0];
            end
            default: begin
            end
         endcase
      end
   end

   wavegen_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_frame_request (req_frame_request),
      .req_ready         (req_ready),
      .status_i          (status),
      .cmd_o             (cmd)
   );

   wavegen_dp #(
      .TABLE_BITS  (TABLE_BITS),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd_i             (cmd),
      .status_o          (status),
      .wave_mode_i       (wave_mode_ff),
      .period_i          (period_ff),
      .channel_count_i   (channel_count_ff),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_sample        (rsp_sample),
      .rsp_channel_index (rsp_channel_index),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for periodic_waveform_generator_core: directed and
// random frame requests with random handshake gaps, checked against a local
// predictor of the sample stream. Depends on wavegen_pkg and the core only.
`timescale 1ns / 1ps

module testbench;
   import wavegen_pkg::*;

   localparam int LUT_BITS       = 12;
   localparam int LUT_SIZE       = 1 << LUT_BITS;
   localparam int LUT_QUARTER    = LUT_SIZE / 4;
   localparam int LUT_MASK       = LUT_SIZE - 1;
   localparam int SETTLE_CYCLES  = 40;
   localparam int RANDOM_FRAMES  = 650;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [2:0] MODE_LAST_CODE = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam real PI = 3.14159265358979323846;

   typedef struct packed {
      logic [15:0] sample;
      logic        channel_index;
      logic        last_of_frame;
   } sample_copy_type;

   // DUT ports
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_frame_request = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_sample;
   logic rsp_channel_index;
   logic rsp_last_of_frame;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0] csr_write_data = '0;

   // Predictor state and settings
   logic [15:0] sine_lut [0:LUT_SIZE-1];
   logic [2:0]  cfg_mode = MODE_RESET;
   logic [15:0] cfg_period = 16'(PERIOD_RESET);
   logic [1:0]  cfg_channels = CHANNEL_RESET;
   logic [15:0] phase_pos = '0;
   logic        ramp_up = 1'b1;

   sample_copy_type pending_copies[$];
   sample_copy_type next_copy;
   int unsigned frames_sent = 0;
   int unsigned copies_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned setting_phases = 0;
   int unsigned stall_left = 0;
   int unsigned ready_roll;
   logic        steady_mode = 1'b0;

   periodic_waveform_generator_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_frame_request (req_frame_request),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample        (rsp_sample),
      .rsp_channel_index (rsp_channel_index),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #10 clock = ~clock;

   // Fill the sine table from quarter-wave magnitudes, mirrored per quadrant
   function automatic void build_sine_lut();
      int unsigned m;
      int unsigned mag;
      for (int k = 0; k < LUT_SIZE; k++) begin
         m = (k & LUT_QUARTER) ? LUT_QUARTER - (k & (LUT_QUARTER - 1))
                               : (k & (LUT_QUARTER - 1));
         if (m == 0) mag = 0;
         else if (m >= LUT_QUARTER) mag = 32767;
         else mag = $rtoi(32767.0 * $sin(2.0 * PI * m / real'(LUT_SIZE)));
         sine_lut[LUT_BITS'(k)] = (k & (2 * LUT_QUARTER)) ? 16'(-mag) : 16'(mag);
      end
   endfunction

   // Compute the sample of one frame, advance phase and queue its copies
   function automatic void predict_frame();
      int unsigned p;
      int unsigned pos;
      int unsigned inc;
      int unsigned idx;
      int unsigned nch;
      logic [LUT_BITS-1:0] lut_idx;
      logic [15:0] value;
      sample_copy_type copy;
      p   = (cfg_period == 0) ? 1 : 32'(cfg_period);
      pos = 32'(phase_pos);
      inc = 65535 / p;
      idx = (pos << LUT_BITS) / p;
      lut_idx = LUT_BITS'(idx & LUT_MASK);
      case (cfg_mode)
         MODE_SINE:   value = sine_lut[lut_idx];
         MODE_COSINE: value = sine_lut[LUT_BITS'(lut_idx + LUT_BITS'(LUT_QUARTER))];
         MODE_SQUARE: value = (pos < p / 2) ? SAMPLE_MIN : SAMPLE_MAX;
         MODE_RISE:   value = 16'(SAMPLE_MIN + pos * inc);
         MODE_FALL:   value = 16'(SAMPLE_MAX - pos * inc);
         default:     value = ramp_up ? 16'(SAMPLE_MIN + pos * inc)
                                      : 16'(SAMPLE_MAX - pos * inc);
      endcase
      if (pos + 1 >= p) begin
         phase_pos = '0;
         if (cfg_mode >= MODE_TRIANGLE) ramp_up = !ramp_up;
      end else begin
         phase_pos = 16'(pos + 1);
      end
      nch = (cfg_channels >= 2) ? 2 : 1;
      for (int unsigned c = 0; c < nch; c++) begin
         copy.sample        = value;
         copy.channel_index = c[0];
         copy.last_of_frame = (c + 1 == nch);
         pending_copies.push_back(copy);
      end
   endfunction

   function automatic void note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one request; valid is left high after acceptance
   task automatic send_request(input logic frame_bit);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_frame_request <= frame_bit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (frame_bit) begin
         predict_frame();
         frames_sent++;
      end
   endtask

   // Drop valid, drain all expected copies, then let the core settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_copies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register while idle and mirror it in the predictor
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_WAVE_MODE:     cfg_mode = data[2:0];
         CSR_PERIOD:        cfg_period = data;
         CSR_CHANNEL_COUNT: cfg_channels = data[1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Reset settings, including an ignored request
   task automatic test_reset_state();
      send_request(1'b0);
      send_request(1'b1);
      send_request(1'b1);
      wait_idle();
   endtask

   // One stereo frame in every mode code, short period
   task automatic test_mode_sweep();
      write_csr(CSR_PERIOD, 16'd3);
      write_csr(CSR_CHANNEL_COUNT, 16'd2);
      for (int m = MODE_SINE; m <= MODE_LAST_CODE; m++) begin
         write_csr(CSR_WAVE_MODE, 16'(m));
         send_request(1'b1);
         wait_idle();
      end
   endtask

   // Zero and full period, channel codes out of range, phase past the period
   task automatic test_period_edges();
      write_csr(CSR_WAVE_MODE, 16'(MODE_TRIANGLE));
      write_csr(CSR_PERIOD, 16'd0);
      write_csr(CSR_CHANNEL_COUNT, 16'd0);
      repeat (3) send_request(1'b1);
      wait_idle();
      write_csr(CSR_CHANNEL_COUNT, 16'd3);
      send_request(1'b1);
      wait_idle();
      write_csr(CSR_WAVE_MODE, 16'(MODE_RISE));
      write_csr(CSR_PERIOD, 16'hFFFF);
      write_csr(CSR_CHANNEL_COUNT, 16'd2);
      repeat (2) send_request(1'b1);
      wait_idle();
      // phase now sits beyond a period of one
      write_csr(CSR_WAVE_MODE, 16'(MODE_SINE));
      write_csr(CSR_PERIOD, 16'd1);
      send_request(1'b1);
      wait_idle();
      // unused index must leave settings alone
      write_csr(CSR_UNUSED, 16'hFFFF);
      send_request(1'b0);
      send_request(1'b1);
      wait_idle();
   endtask

   // Random settings per phase, random request streams in between
   task automatic test_random_traffic();
      int unsigned target;
      int unsigned roll;
      int unsigned count;
      logic [2:0]  mode;
      logic [15:0] period;
      logic [15:0] data;
      target = frames_sent + RANDOM_FRAMES;
      while (frames_sent < target) begin
         setting_phases++;
         mode = 3'($urandom_range(0, 7));
         data = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'd0;
         data[2:0] = mode;
         write_csr(CSR_WAVE_MODE, data);
         roll = $urandom_range(0, 99);
         if (roll < 60) period = 16'($urandom_range(1, 24));
         else if (roll < 85) period = 16'($urandom_range(25, 400));
         else if (roll < 93) period = 16'($urandom_range(401, 4095));
         else if (roll < 96) period = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
         else period = 16'($urandom);
         write_csr(CSR_PERIOD, period);
         data = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'd0;
         data[1:0] = 2'($urandom_range(0, 3));
         write_csr(CSR_CHANNEL_COUNT, data);
         steady_mode <= ($urandom_range(0, 6) == 0);
         count = $urandom_range(8, 50);
         while (count != 0) begin
            if ($urandom_range(0, 9) == 0) begin
               send_request(1'b0);
            end else begin
               send_request(1'b1);
               count--;
            end
         end
         wait_idle();
      end
      steady_mode <= 1'b0;
   endtask

   // Receiver: random stalls, mostly short, a few long
   always @(posedge clock) begin
      if (reset || steady_mode) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 70) begin
            rsp_ready <= 1'b1;
         end else if (ready_roll < 95) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(10, 40);
         end
      end
   end

   // Compare each accepted copy with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_copies.size() == 0) begin
            note_failure($sformatf("unexpected copy sample=%h ch=%0d last=%0d",
                                   rsp_sample, rsp_channel_index, rsp_last_of_frame));
         end else begin
            next_copy = pending_copies.pop_front();
            copies_checked++;
            if (rsp_sample !== next_copy.sample)
               note_failure($sformatf("sample expected %h got %h",
                                      next_copy.sample, rsp_sample));
            if (rsp_channel_index !== next_copy.channel_index)
               note_failure($sformatf("channel_index expected %0d got %0d",
                                      next_copy.channel_index, rsp_channel_index));
            if (rsp_last_of_frame !== next_copy.last_of_frame)
               note_failure($sformatf("last_of_frame expected %0d got %0d",
                                      next_copy.last_of_frame, rsp_last_of_frame));
         end
      end
   end

   initial begin
      build_sine_lut();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_mode_sweep();
      test_period_edges();
      test_random_traffic();
      wait_idle();
      if (pending_copies.size() != 0)
         note_failure($sformatf("%0d copies never arrived", pending_copies.size()));
      $display("summary: %0d frames over %0d random setting phases, %0d copies checked",
               frames_sent, setting_phases, copies_checked);
      $display("summary: all mode codes, zero and full periods, mono and stereo, %0d errors",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Hold a hard limit on run length
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
